>>> hdl/wsfd_pkg.sv
// wsfd_pkg: shared types and constants for the WebSocket frame deframer.
// No dependencies; used by every module under hdl/.
package wsfd_pkg;

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 64;
    localparam int LIMIT_W   = 63;
    localparam int LEN_W     = 64;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 63'd16777216;

    // register index is paddr divided by 8
    localparam logic REG_HARD_LIMIT = 1'b0;

    localparam logic [6:0] LEN7_EXT16   = 7'd126;
    localparam logic [6:0] LEN7_CTL_MAX = 7'd125;
    localparam logic [3:0] EXT16_BYTES  = 4'd2;
    localparam logic [3:0] EXT64_BYTES  = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    typedef enum logic [2:0] {
        ST_LEGAL    = 3'd0,
        ST_RSV      = 3'd1,
        ST_BAD_EXT  = 3'd2,
        ST_RSV_OP   = 3'd3,
        ST_BAD_CTL  = 3'd4,
        ST_UNMASKED = 3'd5
    } status_t;

    typedef enum logic {
        KIND_HEADER  = 1'b0,
        KIND_PAYLOAD = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        status_t           status;
        logic              fin;
        logic [3:0]        opcode;
        logic              masked;
        logic [LEN_W-1:0]  payload_length;
        logic [7:0]        data_byte;
        logic              last;
    } result_t;

endpackage

>>> hdl/wsfd_cfg.sv
// wsfd_cfg: APB-style configuration register holding hard_limit.
// Depends on wsfd_pkg.
module wsfd_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsfd_pkg::ADDR_W-1:0]   paddr,
    input  logic [wsfd_pkg::DATA_W-1:0]   pwdata,
    output logic [wsfd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [wsfd_pkg::LIMIT_W-1:0]  hard_limit
);

    logic [wsfd_pkg::LIMIT_W-1:0] limit_reg;
    logic [wsfd_pkg::LIMIT_W-1:0] limit_next;
    logic                         sel_limit;

    assign pready    = 1'b1;
    assign sel_limit = (paddr[wsfd_pkg::ADDR_W-1] == wsfd_pkg::REG_HARD_LIMIT);

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && sel_limit)
        begin
            limit_next = pwdata[wsfd_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= wsfd_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign prdata     = sel_limit ? {1'b0, limit_reg} : '0;
    assign hard_limit = limit_reg;

endmodule

>>> hdl/wsfd_parser.sv
// wsfd_parser: frame header parser and payload unmasker, one byte per cycle while accept is high.
// Depends on wsfd_pkg; feeds wsfd_outq.
module wsfd_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [7:0]                    stream_byte,
    input  logic                          restart,
    input  logic [wsfd_pkg::LIMIT_W-1:0]  hard_limit,
    output logic                          res_valid,
    output wsfd_pkg::result_t             res
);

    typedef enum logic [4:0] {
        PH_FIRST  = 5'b00001,
        PH_SECOND = 5'b00010,
        PH_EXT    = 5'b00100,
        PH_KEY    = 5'b01000,
        PH_DATA   = 5'b10000
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [3:0]                 cnt_reg, cnt_next;
    logic [7:0]                 b0_reg, b0_next;
    logic [7:0]                 b1_reg, b1_next;
    logic [wsfd_pkg::LEN_W-1:0] len_reg, len_next;
    logic [31:0]                key_reg, key_next;
    logic [wsfd_pkg::LEN_W-1:0] rem_reg, rem_next;
    logic [1:0]                 kidx_reg, kidx_next;
    logic                       halted_reg, halted_next;

    phase_t                     ph;
    logic                       do_finish;
    logic [7:0]                 fin_b1;
    logic [wsfd_pkg::LEN_W-1:0] fin_plen;
    logic [wsfd_pkg::LEN_W-1:0] acc;
    logic [wsfd_pkg::LEN_W-1:0] rem_dec;
    logic [3:0]                 cnt_inc;
    logic [3:0]                 ext_need;
    logic [7:0]                 key_byte;
    logic [6:0]                 len7;
    logic [3:0]                 op;
    wsfd_pkg::status_t          status;

    assign op      = b0_reg[3:0];
    assign len7    = fin_b1[6:0];
    assign cnt_inc = cnt_reg + 4'd1;
    assign acc     = {len_reg[wsfd_pkg::LEN_W-9:0], stream_byte};
    assign rem_dec = rem_reg - 64'd1;
    assign ext_need = (b1_reg[6:0] == wsfd_pkg::LEN7_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                            : wsfd_pkg::EXT64_BYTES;

    always_comb
    begin
        unique case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // legality checks, first failing one wins
    always_comb
    begin
        priority if (b0_reg[6:4] != 3'd0)
            status = wsfd_pkg::ST_RSV;
        else if (len7 >= wsfd_pkg::LEN7_EXT16 &&
                 (fin_plen < 64'd126 || fin_plen > {1'b0, hard_limit}))
            status = wsfd_pkg::ST_BAD_EXT;
        else if ((op >= 4'd3 && op <= 4'd7) || op >= 4'd11)
            status = wsfd_pkg::ST_RSV_OP;
        else if (op[3] && (len7 > wsfd_pkg::LEN7_CTL_MAX || !b0_reg[7]))
            status = wsfd_pkg::ST_BAD_CTL;
        else if (!fin_b1[7] && len7 != 7'd0)
            status = wsfd_pkg::ST_UNMASKED;
        else
            status = wsfd_pkg::ST_LEGAL;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        b0_next     = b0_reg;
        b1_next     = b1_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        kidx_next   = kidx_reg;
        halted_next = halted_reg;
        do_finish   = 1'b0;
        fin_b1      = b1_reg;
        fin_plen    = (b1_reg[6:0] >= wsfd_pkg::LEN7_EXT16) ? len_reg
                                                            : {57'd0, b1_reg[6:0]};
        res_valid   = 1'b0;
        res.kind           = wsfd_pkg::KIND_PAYLOAD;
        res.status         = wsfd_pkg::ST_LEGAL;
        res.fin            = b0_reg[7];
        res.opcode         = b0_reg[3:0];
        res.masked         = b1_reg[7];
        res.payload_length = len_reg;
        res.data_byte      = stream_byte ^ key_byte;
        res.last           = (rem_dec == 64'd0);

        ph = restart ? PH_FIRST : phase_reg;

        if (accept)
        begin
            if (restart)
            begin
                halted_next = 1'b0;
                phase_next  = PH_FIRST;
            end
            if (!halted_reg || restart)
            begin
                unique case (ph)
                    PH_FIRST:
                    begin
                        b0_next    = stream_byte;
                        b1_next    = 8'd0;
                        len_next   = '0;
                        key_next   = '0;
                        cnt_next   = 4'd0;
                        phase_next = PH_SECOND;
                    end
                    PH_SECOND:
                    begin
                        b1_next  = stream_byte;
                        len_next = '0;
                        key_next = '0;
                        cnt_next = 4'd0;
                        if (stream_byte[6:0] >= wsfd_pkg::LEN7_EXT16)
                            phase_next = PH_EXT;
                        else if (stream_byte[7])
                            phase_next = PH_KEY;
                        else
                        begin
                            do_finish = 1'b1;
                            fin_b1    = stream_byte;
                            fin_plen  = {57'd0, stream_byte[6:0]};
                        end
                    end
                    PH_EXT:
                    begin
                        len_next = acc;
                        cnt_next = cnt_inc;
                        if (cnt_inc >= ext_need)
                        begin
                            cnt_next = 4'd0;
                            if (b1_reg[7])
                                phase_next = PH_KEY;
                            else
                            begin
                                do_finish = 1'b1;
                                fin_plen  = acc;
                            end
                        end
                    end
                    PH_KEY:
                    begin
                        key_next = {key_reg[23:0], stream_byte};
                        cnt_next = cnt_inc;
                        if (cnt_inc >= wsfd_pkg::KEY_BYTES)
                        begin
                            cnt_next  = 4'd0;
                            do_finish = 1'b1;
                        end
                    end
                    PH_DATA:
                    begin
                        res_valid = 1'b1;
                        kidx_next = kidx_reg + 2'd1;
                        rem_next  = rem_dec;
                        if (rem_dec == 64'd0)
                            phase_next = PH_FIRST;
                    end
                    default:
                    begin
                        phase_next = PH_FIRST;
                    end
                endcase

                if (do_finish)
                begin
                    res_valid          = 1'b1;
                    res.kind           = wsfd_pkg::KIND_HEADER;
                    res.status         = status;
                    res.masked         = fin_b1[7];
                    res.payload_length = fin_plen;
                    res.data_byte      = 8'd0;
                    res.last           = (fin_plen == 64'd0);
                    len_next           = fin_plen;
                    phase_next         = PH_FIRST;
                    if (status != wsfd_pkg::ST_LEGAL)
                        halted_next = 1'b1;
                    else if (fin_plen != 64'd0)
                    begin
                        phase_next = PH_DATA;
                        rem_next   = fin_plen;
                        kidx_next  = 2'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            cnt_reg    <= 4'd0;
            b0_reg     <= 8'd0;
            b1_reg     <= 8'd0;
            len_reg    <= '0;
            key_reg    <= '0;
            rem_reg    <= '0;
            kidx_reg   <= 2'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            b0_reg     <= b0_next;
            b1_reg     <= b1_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            rem_reg    <= rem_next;
            kidx_reg   <= kidx_next;
            halted_reg <= halted_next;
        end
    end

`ifndef SYNTHESIS
    a_halt_first: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> phase_reg == PH_FIRST)
        else $error("halted outside first header byte phase");
    a_data_rem: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> rem_reg != 64'd0)
        else $error("payload phase with nothing remaining");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < wsfd_pkg::EXT64_BYTES)
        else $error("header byte count out of range");
`endif

endmodule

>>> hdl/wsfd_outq.sv
// wsfd_outq: two-entry result queue between parser and output channel.
// Depends on wsfd_pkg.
module wsfd_outq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsfd_pkg::result_t din,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output wsfd_pkg::result_t dout
);

    wsfd_pkg::result_t ent0_reg;
    wsfd_pkg::result_t ent1_reg;
    logic [1:0]        cnt_reg, cnt_next;
    logic              pop;
    logic              slot;

    assign pop       = (cnt_reg != 2'd0) && out_ready;
    // entry index for an incoming result: count after this cycle's pop
    assign slot      = cnt_reg[0] ^ pop;
    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign dout      = ent0_reg;
    assign cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !slot)
            ent0_reg <= din;
        else if (pop)
            ent0_reg <= ent1_reg;
        if (push && slot)
            ent1_reg <= din;
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("result queue overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full result queue");
    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(ent0_reg))
        else $error("queue head changed while stalled");
`endif

endmodule

>>> hdl/websocket_frame_deframer_top.sv
// websocket_frame_deframer_top: top level of the WebSocket frame deframer.
// Depends on wsfd_pkg, wsfd_cfg, wsfd_parser and wsfd_outq.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one stream byte per transaction
//   plus a restart flag that forces the byte to be parsed as a first header
//   byte. Output channel (out_valid/out_ready) carries header results and
//   unmasked payload bytes; bytes of the header other than the last give no
//   output, nor do bytes dropped after an illegal header.
//   Each result is registered in the result queue before it is presented.
//   Throughput: one byte per cycle while in_ready is high; all parsing is
//   combinational logic ahead of a two-entry result queue.
//   Receiver stall: the queue holds up to two results; in_ready drops only
//   when both entries are occupied, and rises again as soon as one drains.
//   Reset (rst_n low, asynchronous) empties the queue, returns the parser to
//   the first header byte and sets hard_limit to 16777216.
//   hard_limit lives at byte address 0 of the APB port (64-bit data, low 63
//   bits kept); write it only while the block is idle.
module websocket_frame_deframer_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsfd_pkg::ADDR_W-1:0]   paddr,
    input  logic [wsfd_pkg::DATA_W-1:0]   pwdata,
    output logic [wsfd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    stream_byte,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [2:0]                    status,
    output logic                          fin,
    output logic [3:0]                    opcode,
    output logic                          masked,
    output logic [wsfd_pkg::LEN_W-1:0]    payload_length,
    output logic [7:0]                    data_byte,
    output logic                          last
);

    logic [wsfd_pkg::LIMIT_W-1:0] hard_limit;
    logic                         accept;
    logic                         full;
    logic                         res_valid;
    wsfd_pkg::result_t            res;
    wsfd_pkg::result_t            head;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    wsfd_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .hard_limit (hard_limit)
    );

    wsfd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream_byte),
        .restart     (restart),
        .hard_limit  (hard_limit),
        .res_valid   (res_valid),
        .res         (res)
    );

    wsfd_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .din       (res),
        .full      (full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dout      (head)
    );

    assign kind           = head.kind;
    assign status         = head.status;
    assign fin            = head.fin;
    assign opcode         = head.opcode;
    assign masked         = head.masked;
    assign payload_length = head.payload_length;
    assign data_byte      = head.data_byte;
    assign last           = head.last;

endmodule

>>> tb/sv/tb.sv
// tb: self-checking testbench for websocket_frame_deframer_top.
// Depends on wsfd_pkg and the deframer RTL; drives the byte stream and the
// APB port and checks every header and payload result against a local parser.
`timescale 1ns / 100ps

module tb;

    localparam logic [3:0] OP_CONT     = 4'h0;
    localparam logic [3:0] OP_TEXT     = 4'h1;
    localparam logic [3:0] OP_BINARY   = 4'h2;
    localparam logic [3:0] OP_RSV_DATA = 4'h3;
    localparam logic [3:0] OP_CLOSE    = 4'h8;
    localparam logic [3:0] OP_PING     = 4'h9;
    localparam logic [3:0] OP_PONG     = 4'hA;
    localparam logic [3:0] OP_RSV_CTL  = 4'hF;

    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam int ADDR_BITS = wsfd_pkg::ADDR_W;

    // hard_limit is register 0 (byte address 0); address 8 decodes to no register
    localparam logic [ADDR_BITS-1:0] HARD_LIMIT_ADDR = '0;
    localparam logic [ADDR_BITS-1:0] UNUSED_ADDR     = ADDR_BITS'(8);

    localparam int ALL_BYTES   = -1;
    localparam int RANDOM_END  = 1600;
    localparam int TOTAL_BYTES = 1900;
    localparam int STALL_LIMIT = 1000;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD
    } parse_phase_t;

    typedef enum int {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } len_form_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [wsfd_pkg::ADDR_W-1:0]     paddr;
    logic [wsfd_pkg::DATA_W-1:0]     pwdata;
    logic [wsfd_pkg::DATA_W-1:0]     prdata;
    logic                            pready;
    logic                            in_valid;
    logic                            in_ready;
    logic [7:0]                      stream_byte;
    logic                            restart;
    logic                            out_valid;
    logic                            out_ready;
    logic                            kind;
    logic [2:0]                      status;
    logic                            fin;
    logic [3:0]                      opcode;
    logic                            masked;
    logic [wsfd_pkg::LEN_W-1:0]      payload_length;
    logic [7:0]                      data_byte;
    logic                            last;

    // local copy of the parser state
    logic [wsfd_pkg::LIMIT_W-1:0]    p_limit = wsfd_pkg::LIMIT_RESET;
    parse_phase_t                    p_phase = PH_HDR0;
    logic [3:0]                      p_cnt = '0;
    logic [7:0]                      p_hdr0 = '0;
    logic [7:0]                      p_hdr1 = '0;
    logic [63:0]                     p_len = '0;
    logic [31:0]                     p_key = '0;
    logic [63:0]                     p_left = '0;
    logic [1:0]                      p_kidx = '0;
    logic                            p_halted = 1'b0;

    wsfd_pkg::result_t               due_results[$];
    int                              mismatches = 0;
    int                              bytes_sent = 0;
    bit                              idle_on = 1'b1;
    int                              stall_left = 0;
    int                              idle_cycles = 0;

    websocket_frame_deframer_top uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- prediction ----------------

    function automatic void queue_result(wsfd_pkg::kind_t k, wsfd_pkg::status_t s,
                                         logic [7:0] d, logic l);
        wsfd_pkg::result_t r;
        r.kind = k;
        r.status = s;
        r.fin = p_hdr0[7];
        r.opcode = p_hdr0[3:0];
        r.masked = p_hdr1[7];
        r.payload_length = p_len;
        r.data_byte = d;
        r.last = l;
        due_results.push_back(r);
    endfunction

    function automatic void close_header();
        logic [6:0]        len7;
        logic [3:0]        op;
        logic [63:0]       plen;
        wsfd_pkg::status_t st;
        len7 = p_hdr1[6:0];
        op = p_hdr0[3:0];
        plen = (len7 >= wsfd_pkg::LEN7_EXT16) ? p_len : {57'd0, len7};
        if (p_hdr0[6:4] != 3'b000)
            st = wsfd_pkg::ST_RSV;
        else if (len7 >= wsfd_pkg::LEN7_EXT16
                 && (plen < wsfd_pkg::LEN7_EXT16 || plen > {1'b0, p_limit}))
            st = wsfd_pkg::ST_BAD_EXT;
        else if ((op > OP_BINARY && op < OP_CLOSE) || op > OP_PONG)
            st = wsfd_pkg::ST_RSV_OP;
        else if (op[3] && (len7 > wsfd_pkg::LEN7_CTL_MAX || !p_hdr0[7]))
            st = wsfd_pkg::ST_BAD_CTL;
        else if (!p_hdr1[7] && len7 != 7'd0)
            st = wsfd_pkg::ST_UNMASKED;
        else
            st = wsfd_pkg::ST_LEGAL;
        p_len = plen;
        queue_result(wsfd_pkg::KIND_HEADER, st, 8'h00, plen == 64'd0);
        p_phase = PH_HDR0;
        if (st != wsfd_pkg::ST_LEGAL)
            p_halted = 1'b1;
        else if (plen != 64'd0)
        begin
            p_phase = PH_PAYLOAD;
            p_left = plen;
            p_kidx = '0;
        end
    endfunction

    function automatic void deframe_byte(logic [7:0] b, logic rs);
        int sh;
        if (rs)
        begin
            p_halted = 1'b0;
            p_phase = PH_HDR0;
        end
        if (p_halted)
            return;
        case (p_phase)
            PH_HDR1:
            begin
                p_hdr1 = b;
                p_len = '0;
                p_key = '0;
                p_cnt = '0;
                if (b[6:0] >= wsfd_pkg::LEN7_EXT16)
                    p_phase = PH_EXTLEN;
                else if (b[7])
                    p_phase = PH_KEY;
                else
                    close_header();
            end
            PH_EXTLEN:
            begin
                p_len = {p_len[55:0], b};
                p_cnt = p_cnt + 4'd1;
                if (p_cnt == ((p_hdr1[6:0] == wsfd_pkg::LEN7_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                                    : wsfd_pkg::EXT64_BYTES))
                begin
                    p_cnt = '0;
                    if (p_hdr1[7])
                        p_phase = PH_KEY;
                    else
                        close_header();
                end
            end
            PH_KEY:
            begin
                p_key = {p_key[23:0], b};
                p_cnt = p_cnt + 4'd1;
                if (p_cnt == wsfd_pkg::KEY_BYTES)
                begin
                    p_cnt = '0;
                    close_header();
                end
            end
            PH_PAYLOAD:
            begin
                // first key byte received sits in the top byte of p_key
                sh = 8 * (3 - int'(p_kidx));
                p_kidx = p_kidx + 2'd1;
                p_left = p_left - 64'd1;
                if (p_left == 64'd0)
                    p_phase = PH_HDR0;
                queue_result(wsfd_pkg::KIND_PAYLOAD, wsfd_pkg::ST_LEGAL, b ^ p_key[sh +: 8],
                             p_left == 64'd0);
            end
            default:
            begin
                p_hdr0 = b;
                p_hdr1 = '0;
                p_len = '0;
                p_key = '0;
                p_cnt = '0;
                p_phase = PH_HDR1;
            end
        endcase
    endfunction

    // ---------------- result checking ----------------

    function automatic string fmt_result(wsfd_pkg::result_t r);
        return $sformatf("kind=%0d status=%0d fin=%0d op=%h masked=%0d len=%0d data=%h last=%0d",
                         r.kind, r.status, r.fin, r.opcode, r.masked, r.payload_length,
                         r.data_byte, r.last);
    endfunction

    function automatic void check_result();
        wsfd_pkg::result_t want;
        wsfd_pkg::result_t got;
        got.kind = wsfd_pkg::kind_t'(kind);
        got.status = wsfd_pkg::status_t'(status);
        got.fin = fin;
        got.opcode = opcode;
        got.masked = masked;
        got.payload_length = payload_length;
        got.data_byte = data_byte;
        got.last = last;
        if (due_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("tb: result with none pending at %0t: %s", $realtime, fmt_result(got));
            return;
        end
        want = due_results.pop_front();
        if (kind !== want.kind || status !== want.status || fin !== want.fin
            || opcode !== want.opcode || masked !== want.masked
            || payload_length !== want.payload_length || data_byte !== want.data_byte
            || last !== want.last)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("tb: mismatch at %0t", $realtime);
                $display("  expected %s", fmt_result(want));
                $display("  actual   %s", fmt_result(got));
            end
        end
    endfunction

    // receiver: checks each accepted transaction, stalls in random bursts while idle_on is set
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_result();
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog: no transaction on any port for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic send_byte(input logic [7:0] b, input logic rs);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        stream_byte <= b;
        restart <= rs;
        do
            @(posedge clk);
        while (!in_ready);
        deframe_byte(b, rs);
        bytes_sent++;
    endtask

    task automatic send_body(input int n);
        repeat (n) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_header(input logic [7:0] b0, input logic msk, input len_form_t form,
                               input logic [63:0] len, input logic [31:0] key,
                               input logic rs, input int keep);
        logic [7:0] hdr[$];
        logic [6:0] len7;
        int         n;
        case (form)
            LEN_SHORT: len7 = len[6:0];
            LEN_EXT16: len7 = wsfd_pkg::LEN7_EXT16;
            default:   len7 = LEN7_EXT64;
        endcase
        hdr.push_back(b0);
        hdr.push_back({msk, len7});
        if (form == LEN_EXT16)
        begin
            hdr.push_back(len[15:8]);
            hdr.push_back(len[7:0]);
        end
        else if (form == LEN_EXT64)
            for (int i = 7; i >= 0; i--)
                hdr.push_back(len[8*i +: 8]);
        if (msk)
            for (int i = 3; i >= 0; i--)
                hdr.push_back(key[8*i +: 8]);
        n = (keep < 0 || keep > hdr.size()) ? hdr.size() : keep;
        for (int i = 0; i < n; i++)
            send_byte(hdr[i], (i == 0) ? rs : 1'b0);
    endtask

    // drop valid and hold off until every pending result has drained
    task automatic wait_settled();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write followed by a read-back of hard_limit
    task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == HARD_LIMIT_ADDR)
            p_limit = value[wsfd_pkg::LIMIT_W-1:0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= HARD_LIMIT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {1'b0, p_limit})
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("tb: hard_limit read-back expected %h actual %h",
                         {1'b0, p_limit}, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random_frame();
        logic [3:0]  op;
        logic [2:0]  rsv;
        logic        fin_bit;
        logic        msk;
        logic        rs;
        logic [63:0] len;
        len_form_t   form;
        int          keep;
        int          body;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)
        begin
            // line noise, sometimes with restart
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom), $urandom_range(0, 4) == 0);
            return;
        end
        if ($urandom_range(0, 3) == 0)
            op = 4'($urandom);
        else
            case ($urandom_range(0, 5))
                0: op = OP_CONT;
                1: op = OP_TEXT;
                2: op = OP_BINARY;
                3: op = OP_CLOSE;
                4: op = OP_PING;
                default: op = OP_PONG;
            endcase
        rsv = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'b000;
        fin_bit = op[3] ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) != 0);
        msk = ($urandom_range(0, 9) != 0);
        sel = $urandom_range(0, 99);
        if (sel < 80)
        begin
            form = LEN_SHORT;
            len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 125))
                                              : 64'($urandom_range(0, 20));
        end
        else if (sel < 92)
        begin
            form = LEN_EXT16;
            case ($urandom_range(0, 3))
                0: len = 64'($urandom_range(0, 125));
                1: len = 64'($urandom_range(0, 65535));
                default: len = 64'($urandom_range(126, 300));
            endcase
        end
        else
        begin
            form = LEN_EXT64;
            case ($urandom_range(0, 3))
                0: len = {$urandom, $urandom};
                1: len = 64'($urandom_range(0, 125));
                2: len = {1'b0, p_limit} + 64'($urandom_range(0, 1));
                default: len = 64'($urandom_range(126, 300));
            endcase
        end
        rs = (p_halted || p_phase != PH_HDR0) ? 1'b1 : ($urandom_range(0, 6) == 0);
        keep = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 13) : ALL_BYTES;
        send_header({fin_bit, rsv, op}, msk, form, len, 32'($urandom), rs, keep);
        if (keep != ALL_BYTES)
            return;
        if (p_halted)
            body = $urandom_range(0, 3);
        else if (p_phase == PH_PAYLOAD)
        begin
            if (p_left <= 64'd300 && $urandom_range(0, 9) != 0)
                body = int'(p_left);
            else if (p_left <= 64'd40)
                body = $urandom_range(0, int'(p_left));
            else
                body = $urandom_range(0, 40);
        end
        else
            body = 0;
        send_body(body);
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_frames();
        // empty close frame, unmasked: legal, header marked last
        send_header({1'b1, 3'b000, OP_CLOSE}, 1'b0, LEN_SHORT, 64'd0, 32'h0, 1'b0, ALL_BYTES);
        // masked text frame: key order and payload unmasking
        send_header({1'b1, 3'b000, OP_TEXT}, 1'b1, LEN_SHORT, 64'd3, 32'hA1B2C3D4, 1'b0,
                    ALL_BYTES);
        send_body(3);
        // reserved bits set, then a byte that must be dropped
        send_header({1'b1, 3'b111, OP_BINARY}, 1'b0, LEN_SHORT, 64'd0, 32'h0, 1'b0, ALL_BYTES);
        send_body(1);
        // reserved opcode
        send_header({1'b1, 3'b000, OP_RSV_CTL}, 1'b0, LEN_SHORT, 64'd0, 32'h0, 1'b1, ALL_BYTES);
        // fragmented ping is a bad control frame
        send_header({1'b0, 3'b000, OP_PING}, 1'b0, LEN_SHORT, 64'd0, 32'h0, 1'b1, ALL_BYTES);
        // unmasked payload at the largest short length
        send_header({1'b1, 3'b000, OP_BINARY}, 1'b0, LEN_SHORT, 64'd125, 32'h0, 1'b1,
                    ALL_BYTES);
        // 16-bit extended length that should have been short
        send_header({1'b1, 3'b000, OP_BINARY}, 1'b0, LEN_EXT16, 64'd125, 32'h0, 1'b1,
                    ALL_BYTES);
    endtask

    task automatic test_hard_limit_sweep();
        logic [63:0] v;
        logic [63:0] probe;
        for (int s = 0; s < 8; s++)
        begin
            wait_settled();
            case (s)
                1: v = 64'd0;
                2: v = 64'd126;
                3: v = 64'd65535;
                4: v = {1'b0, {63{1'b1}}};
                5: v = {64{1'b1}};
                6: v = 64'h8000_0000_0000_0000;   // top bit dropped: limit becomes 0
                default: v = 64'd400;
            endcase
            if (s > 0)
                write_reg(HARD_LIMIT_ADDR, v);
            if (s == 3)
                write_reg(UNUSED_ADDR, {$urandom, $urandom});
            for (int j = 0; j < 6; j++)
            begin
                case (j)
                    0: probe = {1'b0, p_limit};
                    1: probe = {1'b0, p_limit} + 64'd1;
                    2: probe = 64'd125;
                    3: probe = 64'd126;
                    4: probe = 64'h8000_0000_0000_0000;
                    default: probe = {64{1'b1}};
                endcase
                send_header({1'b1, 3'b000, OP_BINARY}, j[0], LEN_EXT64, probe, 32'($urandom),
                            1'b1, ALL_BYTES);
                if (p_phase == PH_PAYLOAD)
                    send_body(2);
            end
            probe = (p_limit > 63'd65534) ? 64'd65534 : {1'b0, p_limit};
            for (int j = 0; j < 2; j++)
            begin
                send_header({1'b1, 3'b000, OP_TEXT}, 1'b1, LEN_EXT16, probe + 64'(j),
                            32'($urandom), 1'b1, ALL_BYTES);
                if (p_phase == PH_PAYLOAD)
                    send_body(2);
            end
            // control frame with an extended length
            send_header({1'b1, 3'b000, OP_CLOSE}, 1'b1, LEN_EXT16, 64'd200, 32'($urandom),
                        1'b1, ALL_BYTES);
        end
    endtask

    task automatic test_random_stream();
        idle_on = 1'b1;
        while (bytes_sent < RANDOM_END)
        begin
            if ($urandom_range(0, 19) == 0)
                idle_on = !idle_on;
            if ($urandom_range(0, 49) == 0)
                wait_settled();
            send_random_frame();
        end
    endtask

    task automatic test_full_rate();
        wait_settled();
        write_reg(HARD_LIMIT_ADDR, 64'(wsfd_pkg::LIMIT_RESET));
        idle_on = 1'b0;
        while (bytes_sent < TOTAL_BYTES)
            send_random_frame();
    endtask

    initial
    begin
        in_valid <= 1'b0;
        stream_byte <= '0;
        restart <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_hard_limit_sweep();
        test_random_stream();
        test_full_rate();

        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
